FILE: src/plb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plb_pkg
// Shared types and constants for the price level book.
// ----------------------------------------------------------------------------
package plb_pkg;

    // default sizing
    localparam int LEVELS_DEF     = 64;
    localparam int PRICE_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF = 16;

    // fixed port widths
    localparam int PRICE_PORT_W  = 32;
    localparam int SPREAD_PORT_W = 33;

    typedef enum logic {
        CMD_ADD    = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic {
        SIDE_BID = 1'b0,
        SIDE_ASK = 1'b1
    } t_side;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } t_status;

    // update control broadcast along a row of cells
    typedef struct packed {
        logic upd;   // this row takes the update this cycle
        t_cmd cmd;
        logic hit;   // some cell matches the request price
        logic del;   // matching level drops to zero orders
        logic full;  // last cell occupied
    } t_cell_ctrl;

    // row summary seen by the top level
    typedef struct packed {
        logic hit;
        logic full;
    } t_row_stat;

endpackage

FILE: src/plb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plb_cell
// One price level: valid, price and order count, with compare flags and
// shift-in paths from both neighbors.
// ----------------------------------------------------------------------------
module plb_cell #(
    parameter int PRICE_BITS = plb_pkg::PRICE_BITS_DEF,
    parameter int COUNT_BITS = plb_pkg::COUNT_BITS_DEF,
    parameter bit IS_ASK     = 1'b0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cmp,
    input  logic [PRICE_BITS-1:0]   i_cmp_price,
    input  plb_pkg::t_cell_ctrl     i_ctrl,
    input  logic [PRICE_BITS-1:0]   i_new_price,
    input  logic                    i_left_valid,
    input  logic [PRICE_BITS-1:0]   i_left_price,
    input  logic [COUNT_BITS-1:0]   i_left_count,
    input  logic                    i_left_ahead,
    input  logic                    i_right_valid,
    input  logic [PRICE_BITS-1:0]   i_right_price,
    input  logic [COUNT_BITS-1:0]   i_right_count,
    output logic                    o_valid,
    output logic [PRICE_BITS-1:0]   o_price,
    output logic [COUNT_BITS-1:0]   o_count,
    output logic                    o_ahead,
    output logic                    o_match,
    output logic                    o_last
);

    logic                  r_valid, n_valid;
    logic [PRICE_BITS-1:0] r_price, n_price;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_ahead, n_ahead;
    logic                  r_match, n_match;
    logic                  r_last,  n_last;

    // compare against the incoming request price
    always_comb begin
        if (IS_ASK) begin
            n_ahead = r_valid && (r_price < i_cmp_price);
        end else begin
            n_ahead = r_valid && (r_price > i_cmp_price);
        end
        n_match = r_valid && (r_price == i_cmp_price);
        n_last  = n_match && (r_count <= COUNT_BITS'(1));
    end

    // level update: bump, insert/shift right, decrement, or delete/shift left
    always_comb begin
        n_valid = r_valid;
        n_price = r_price;
        n_count = r_count;
        if (i_ctrl.upd) begin
            if (i_ctrl.cmd == plb_pkg::CMD_ADD) begin
                if (i_ctrl.hit) begin
                    if (r_match && (r_count != '1)) begin
                        n_count = r_count + COUNT_BITS'(1);
                    end
                end else if (!i_ctrl.full && !r_ahead) begin
                    if (i_left_ahead) begin
                        n_valid = 1'b1;
                        n_price = i_new_price;
                        n_count = COUNT_BITS'(1);
                    end else begin
                        n_valid = i_left_valid;
                        n_price = i_left_price;
                        n_count = i_left_count;
                    end
                end
            end else if (i_ctrl.hit) begin
                if (!i_ctrl.del) begin
                    if (r_match) begin
                        n_count = r_count - COUNT_BITS'(1);
                    end
                end else if (!r_ahead) begin
                    n_valid = i_right_valid;
                    n_price = i_right_price;
                    n_count = i_right_count;
                end
            end
        end
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // level contents and compare flags
    always_ff @(posedge i_clk) begin
        r_price <= n_price;
        r_count <= n_count;
        if (i_cmp) begin
            r_ahead <= n_ahead;
            r_match <= n_match;
            r_last  <= n_last;
        end
    end

    assign o_valid = r_valid;
    assign o_price = r_price;
    assign o_count = r_count;
    assign o_ahead = r_ahead;
    assign o_match = r_match;
    assign o_last  = r_last;

endmodule

FILE: src/plb_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plb_row
// One side of the book: a sorted chain of level cells, best level in cell 0.
// ----------------------------------------------------------------------------
module plb_row #(
    parameter int LEVELS     = plb_pkg::LEVELS_DEF,
    parameter int PRICE_BITS = plb_pkg::PRICE_BITS_DEF,
    parameter int COUNT_BITS = plb_pkg::COUNT_BITS_DEF,
    parameter bit IS_ASK     = 1'b0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmp,
    input  logic [PRICE_BITS-1:0] i_cmp_price,
    input  logic                  i_upd,
    input  plb_pkg::t_cmd         i_cmd,
    input  logic [PRICE_BITS-1:0] i_new_price,
    output plb_pkg::t_row_stat    o_stat,
    output logic                  o_head_valid,
    output logic [PRICE_BITS-1:0] o_head_price
);

    logic [LEVELS-1:0]     w_valid;
    logic [LEVELS-1:0]     w_ahead;
    logic [LEVELS-1:0]     w_match;
    logic [LEVELS-1:0]     w_last;
    logic [PRICE_BITS-1:0] w_price [LEVELS];
    logic [COUNT_BITS-1:0] w_count [LEVELS];
    plb_pkg::t_cell_ctrl   w_ctrl;

    // row-wide decisions from the registered compare flags
    always_comb begin
        w_ctrl.upd  = i_upd;
        w_ctrl.cmd  = i_cmd;
        w_ctrl.hit  = |w_match;
        w_ctrl.del  = |w_last;
        w_ctrl.full = w_valid[LEVELS-1];
    end

    // cell chain; cell 0 sees a virtual head that always ranks ahead
    for (genvar g = 0; g < LEVELS; g++) begin : g_cell
        logic                  w_lv, w_la, w_rv;
        logic [PRICE_BITS-1:0] w_lp, w_rp;
        logic [COUNT_BITS-1:0] w_lc, w_rc;

        if (g == 0) begin : g_head
            assign w_lv = 1'b0;
            assign w_lp = '0;
            assign w_lc = '0;
            assign w_la = 1'b1;
        end else begin : g_mid
            assign w_lv = w_valid[g-1];
            assign w_lp = w_price[g-1];
            assign w_lc = w_count[g-1];
            assign w_la = w_ahead[g-1];
        end

        if (g == LEVELS - 1) begin : g_tail
            assign w_rv = 1'b0;
            assign w_rp = '0;
            assign w_rc = '0;
        end else begin : g_body
            assign w_rv = w_valid[g+1];
            assign w_rp = w_price[g+1];
            assign w_rc = w_count[g+1];
        end

        plb_cell #(
            .PRICE_BITS (PRICE_BITS),
            .COUNT_BITS (COUNT_BITS),
            .IS_ASK     (IS_ASK)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmp         (i_cmp),
            .i_cmp_price   (i_cmp_price),
            .i_ctrl        (w_ctrl),
            .i_new_price   (i_new_price),
            .i_left_valid  (w_lv),
            .i_left_price  (w_lp),
            .i_left_count  (w_lc),
            .i_left_ahead  (w_la),
            .i_right_valid (w_rv),
            .i_right_price (w_rp),
            .i_right_count (w_rc),
            .o_valid       (w_valid[g]),
            .o_price       (w_price[g]),
            .o_count       (w_count[g]),
            .o_ahead       (w_ahead[g]),
            .o_match       (w_match[g]),
            .o_last        (w_last[g])
        );
    end

    assign o_stat.hit   = w_ctrl.hit;
    assign o_stat.full  = w_ctrl.full;
    assign o_head_valid = w_valid[0];
    assign o_head_price = w_price[0];

endmodule

FILE: src/price_level_book_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_book_top
// Bid and ask price level tables with best-price and spread reporting.
// ----------------------------------------------------------------------------
// Each side is a sorted chain of LEVELS cells, best level in cell 0. A request
// is taken when start is high and busy is low; the cells compare their prices
// in that same cycle, the whole chain inserts, bumps, decrements or deletes
// in the next cycle (busy high), and the result is shown with o_result_valid
// for one cycle right after. That result cycle also takes a new request, so
// a new request can overlap the result of the last. Results cannot be held
// off. An add to a full side is dropped with status full; a remove of an
// absent price reports not found.
// ----------------------------------------------------------------------------
module price_level_book_top #(
    parameter int LEVELS     = plb_pkg::LEVELS_DEF,
    parameter int PRICE_BITS = plb_pkg::PRICE_BITS_DEF,
    parameter int COUNT_BITS = plb_pkg::COUNT_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    i_cmd,
    input  logic                                    i_side,
    input  logic [plb_pkg::PRICE_PORT_W-1:0]        i_price,
    output logic                                    o_result_valid,
    output logic [1:0]                              o_status,
    output logic                                    o_bid_valid,
    output logic [plb_pkg::PRICE_PORT_W-1:0]        o_top_bid,
    output logic                                    o_ask_valid,
    output logic [plb_pkg::PRICE_PORT_W-1:0]        o_top_ask,
    output logic signed [plb_pkg::SPREAD_PORT_W-1:0] o_spread_ticks
);

    localparam int PW = plb_pkg::PRICE_PORT_W;
    localparam int SW = plb_pkg::SPREAD_PORT_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_UPD  = 3'b010,
        ST_OUT  = 3'b100
    } t_state;

    t_state                r_state, n_state;
    plb_pkg::t_cmd         r_cmd;
    plb_pkg::t_side        r_side;
    logic [PRICE_BITS-1:0] r_price;
    plb_pkg::t_status      r_status, n_status;

    logic                  w_accept;
    logic [PRICE_BITS-1:0] w_price;
    plb_pkg::t_row_stat    w_bid_stat, w_ask_stat, w_sel_stat;
    logic                  w_bid_v, w_ask_v;
    logic [PRICE_BITS-1:0] w_bid_p, w_ask_p;
    logic [PRICE_BITS-1:0] w_top_bid, w_top_ask;
    logic [PRICE_BITS:0]   w_spread;

    assign busy     = (r_state == ST_UPD);
    assign w_accept = start && !busy;

    // request price at the internal width
    if (PRICE_BITS >= PW) begin : g_pin_wide
        assign w_price = {{(PRICE_BITS-PW){1'b0}}, i_price};
    end else begin : g_pin_narrow
        assign w_price = i_price[PRICE_BITS-1:0];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: n_state = w_accept ? ST_UPD : ST_IDLE;
            ST_UPD:  n_state = ST_OUT;
            ST_OUT:  n_state = w_accept ? ST_UPD : ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request hold register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= plb_pkg::t_cmd'(i_cmd);
            r_side  <= plb_pkg::t_side'(i_side);
            r_price <= w_price;
        end
        if (busy) begin
            r_status <= n_status;
        end
    end

    // status of the request being applied
    assign w_sel_stat = (r_side == plb_pkg::SIDE_ASK) ? w_ask_stat : w_bid_stat;

    always_comb begin
        n_status = plb_pkg::STATUS_OK;
        if (!w_sel_stat.hit) begin
            if (r_cmd == plb_pkg::CMD_REMOVE) begin
                n_status = plb_pkg::STATUS_NOT_FOUND;
            end else if (w_sel_stat.full) begin
                n_status = plb_pkg::STATUS_FULL;
            end
        end
    end

    // bid side, highest first
    plb_row #(
        .LEVELS     (LEVELS),
        .PRICE_BITS (PRICE_BITS),
        .COUNT_BITS (COUNT_BITS),
        .IS_ASK     (1'b0)
    ) u_bid_row (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmp        (w_accept),
        .i_cmp_price  (w_price),
        .i_upd        (busy && (r_side == plb_pkg::SIDE_BID)),
        .i_cmd        (r_cmd),
        .i_new_price  (r_price),
        .o_stat       (w_bid_stat),
        .o_head_valid (w_bid_v),
        .o_head_price (w_bid_p)
    );

    // ask side, lowest first
    plb_row #(
        .LEVELS     (LEVELS),
        .PRICE_BITS (PRICE_BITS),
        .COUNT_BITS (COUNT_BITS),
        .IS_ASK     (1'b1)
    ) u_ask_row (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmp        (w_accept),
        .i_cmp_price  (w_price),
        .i_upd        (busy && (r_side == plb_pkg::SIDE_ASK)),
        .i_cmd        (r_cmd),
        .i_new_price  (r_price),
        .o_stat       (w_ask_stat),
        .o_head_valid (w_ask_v),
        .o_head_price (w_ask_p)
    );

    // best prices and spread from the head cells
    assign w_top_bid = w_bid_v ? w_bid_p : '0;
    assign w_top_ask = w_ask_v ? w_ask_p : '1;
    assign w_spread  = (w_bid_v && w_ask_v) ?
                       ({1'b0, w_ask_p} - {1'b0, w_bid_p}) : '0;

    if (PRICE_BITS >= PW) begin : g_pout_wide
        assign o_top_bid = w_top_bid[PW-1:0];
        assign o_top_ask = w_top_ask[PW-1:0];
    end else begin : g_pout_narrow
        assign o_top_bid = {{(PW-PRICE_BITS){1'b0}}, w_top_bid};
        assign o_top_ask = {{(PW-PRICE_BITS){1'b0}}, w_top_ask};
    end

    if (PRICE_BITS + 1 >= SW) begin : g_sp_wide
        assign o_spread_ticks = w_spread[SW-1:0];
    end else begin : g_sp_narrow
        assign o_spread_ticks = {{(SW-PRICE_BITS-1){1'b0}}, w_spread};
    end

    assign o_result_valid = (r_state == ST_OUT);
    assign o_status       = r_status;
    assign o_bid_valid    = w_bid_v;
    assign o_ask_valid    = w_ask_v;

endmodule

FILE: src/plb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plb_checker
// Port-level checks for the price level book, bound to the top level.
// ----------------------------------------------------------------------------
module plb_checker (
    input logic                                     i_clk,
    input logic                                     i_rst_n,
    input logic                                     start,
    input logic                                     busy,
    input logic                                     o_result_valid,
    input logic                                     o_bid_valid,
    input logic [plb_pkg::PRICE_PORT_W-1:0]         o_top_bid,
    input logic                                     o_ask_valid,
    input logic signed [plb_pkg::SPREAD_PORT_W-1:0] o_spread_ticks
);

    // an accepted request puts the block into its update state
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without entering update");

    // every update cycle is followed by exactly one result
    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_result_valid && !busy))
        else $error("update not followed by a result");

    // each result traces back to an earlier accepted request
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, 2))
        else $error("result without a matching request");

    // spread reads zero unless both sides hold a level
    a_spread_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !(o_bid_valid && o_ask_valid)) |-> (o_spread_ticks == '0))
        else $error("nonzero spread with an empty side");

    // empty bid side reports zero
    a_bid_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_bid_valid) |-> (o_top_bid == '0))
        else $error("top bid nonzero on empty bid side");

endmodule

bind price_level_book_top plb_checker u_plb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_bid_valid    (o_bid_valid),
    .o_top_bid      (o_top_bid),
    .o_ask_valid    (o_ask_valid),
    .o_spread_ticks (o_spread_ticks)
);

FILE: tb/sv/plb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plb_tb_checker
// Watches the request and result ports of the price level book, keeps its own
// copy of both level tables and compares every result against it.
// ----------------------------------------------------------------------------
module plb_tb_checker
    import plb_pkg::*;
#(
    parameter int LEVELS     = LEVELS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  logic                            i_cmd,
    input  logic                            i_side,
    input  logic [PRICE_PORT_W-1:0]         i_price,
    input  logic                            i_result_valid,
    input  logic [1:0]                      i_status,
    input  logic                            i_bid_valid,
    input  logic [PRICE_PORT_W-1:0]         i_top_bid,
    input  logic                            i_ask_valid,
    input  logic [PRICE_PORT_W-1:0]         i_top_ask,
    input  logic signed [SPREAD_PORT_W-1:0] i_spread_ticks,
    output int                              o_mismatches,
    output int                              o_pending
);

    // what the book reports after one request
    typedef struct packed {
        t_status                         status;
        logic                            bid_valid;
        logic [PRICE_PORT_W-1:0]         top_bid;
        logic                            ask_valid;
        logic [PRICE_PORT_W-1:0]         top_ask;
        logic signed [SPREAD_PORT_W-1:0] spread;
    } t_book_view;

    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;

    // index 0 holds bids (highest first), index 1 asks (lowest first)
    logic [PRICE_PORT_W-1:0] level_px  [2][LEVELS];
    longint unsigned         level_cnt [2][LEVELS];
    int                      level_used[2];

    t_book_view views_due[$];

    // Apply one request to the shadow tables and return the expected view.
    // PRICE_BITS equals the port width, so prices need no masking.
    function automatic t_book_view book_update(input t_cmd cmd, input t_side sd,
                                               input logic [PRICE_PORT_W-1:0] px);
        int         s;
        int         n;
        int         pos;
        int         j;
        logic       hit;
        t_book_view v;
        s   = (sd == SIDE_ASK) ? 1 : 0;
        n   = level_used[s];
        pos = 0;
        // walk past every level that ranks ahead of this price
        while (pos < n && ((sd == SIDE_BID) ? (level_px[s][pos] > px)
                                             : (level_px[s][pos] < px)))
            pos++;
        hit = (pos < n) && (level_px[s][pos] == px);
        v.status = STATUS_OK;

        if (cmd == CMD_ADD) begin
            if (hit) begin
                // count saturates at its maximum
                if (level_cnt[s][pos] < COUNT_MAX)
                    level_cnt[s][pos]++;
            end else if (n >= LEVELS) begin
                v.status = STATUS_FULL;
            end else begin
                for (j = n; j > pos; j--) begin
                    level_px[s][j]  = level_px[s][j-1];
                    level_cnt[s][j] = level_cnt[s][j-1];
                end
                level_px[s][pos]  = px;
                level_cnt[s][pos] = 1;
                level_used[s]     = n + 1;
            end
        end else begin
            if (!hit) begin
                v.status = STATUS_NOT_FOUND;
            end else if (level_cnt[s][pos] > 1) begin
                level_cnt[s][pos]--;
            end else begin
                for (j = pos; j + 1 < n; j++) begin
                    level_px[s][j]  = level_px[s][j+1];
                    level_cnt[s][j] = level_cnt[s][j+1];
                end
                level_used[s] = n - 1;
            end
        end

        // top of book and spread, zero spread unless both sides hold levels
        v.bid_valid = (level_used[0] != 0);
        v.ask_valid = (level_used[1] != 0);
        v.top_bid   = v.bid_valid ? level_px[0][0] : '0;
        v.top_ask   = v.ask_valid ? level_px[1][0] : '1;
        v.spread    = (v.bid_valid && v.ask_valid)
                    ? ({1'b0, v.top_ask} - {1'b0, v.top_bid}) : '0;
        return v;
    endfunction

    task automatic check_field(input string field, input logic [SPREAD_PORT_W-1:0] want,
                               input logic [SPREAD_PORT_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            o_mismatches++;
        end
    endtask

    // results are checked before the request of the same edge is predicted
    always @(posedge i_clk) begin
        t_book_view due;
        if (!i_rst_n) begin
            level_used[0] = 0;
            level_used[1] = 0;
            views_due.delete();
        end else begin
            if (i_result_valid) begin
                if (views_due.size() == 0) begin
                    $error("result strobe with no request outstanding");
                    o_mismatches++;
                end else begin
                    due = views_due.pop_front();
                    check_field("status",       due.status,    i_status);
                    check_field("bid_valid",    due.bid_valid, i_bid_valid);
                    check_field("top_bid",      due.top_bid,   i_top_bid);
                    check_field("ask_valid",    due.ask_valid, i_ask_valid);
                    check_field("top_ask",      due.top_ask,   i_top_ask);
                    check_field("spread_ticks", due.spread,    i_spread_ticks);
                end
            end
            if (i_start && !i_busy)
                views_due.push_back(book_update(t_cmd'(i_cmd), t_side'(i_side), i_price));
        end
        o_pending = views_due.size();
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives order requests into the price level book and gives the verdict.
// A directed pass covers empty sides, extreme prices, crossed books and
// inserts/deletes at head, middle and tail; a burst on one level stacks many
// orders on it and drains them again; random add-heavy and remove-heavy
// phases then fill sides to capacity and drain them again.
// Checking is done by plb_tb_checker.
// ----------------------------------------------------------------------------
module tb;
    import plb_pkg::*;

    localparam int RANDOM_REQS  = 1400;
    localparam int PHASE_LEN    = 250;
    localparam int BURST_ORDERS = 40;
    // longest legal silence is the longest request gap that pick_gap draws
    localparam int IDLE_LIMIT   = 2000;
    localparam logic [PRICE_PORT_W-1:0] BURST_PRICE = 32'hA5A5_5A5A;

    typedef struct packed {
        t_side                   sd;
        logic [PRICE_PORT_W-1:0] px;
    } t_resting;

    logic                            i_clk     = 1'b0;
    logic                            i_rst_n   = 1'b0;
    logic                            start     = 1'b0;
    t_cmd                            req_cmd   = CMD_ADD;
    t_side                           req_side  = SIDE_BID;
    logic [PRICE_PORT_W-1:0]         req_price = '0;
    logic                            busy;
    logic                            result_valid;
    logic [1:0]                      status;
    logic                            bid_valid;
    logic [PRICE_PORT_W-1:0]         top_bid;
    logic                            ask_valid;
    logic [PRICE_PORT_W-1:0]         top_ask;
    logic signed [SPREAD_PORT_W-1:0] spread_ticks;
    int                              mismatches;
    int                              pending;
    int                              idle_cycles;
    bit                              no_idle;

    // orders believed to be resting, used to aim removes at live levels
    t_resting resting[$];

    always #5 i_clk = ~i_clk;

    price_level_book_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (req_cmd),
        .i_side         (req_side),
        .i_price        (req_price),
        .o_result_valid (result_valid),
        .o_status       (status),
        .o_bid_valid    (bid_valid),
        .o_top_bid      (top_bid),
        .o_ask_valid    (ask_valid),
        .o_top_ask      (top_ask),
        .o_spread_ticks (spread_ticks)
    );

    plb_tb_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_cmd          (req_cmd),
        .i_side         (req_side),
        .i_price        (req_price),
        .i_result_valid (result_valid),
        .i_status       (status),
        .i_bid_valid    (bid_valid),
        .i_top_bid      (top_bid),
        .i_ask_valid    (ask_valid),
        .i_top_ask      (top_ask),
        .i_spread_ticks (spread_ticks),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // extremes, full-range values, or a cluster around the phase base
    function automatic logic [PRICE_PORT_W-1:0] fresh_price(input logic [PRICE_PORT_W-1:0] base);
        logic [PRICE_PORT_W-1:0] px;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       px = '0;
                    1:       px = '1;
                    2:       px = 32'd1;
                    default: px = 32'hFFFF_FFFE;
                endcase
            end
            1: px = $urandom;
            default: px = base + $urandom_range(0, 255) - 128;
        endcase
        return px;
    endfunction

    // present one request, hold it until taken, then idle a random while
    task automatic send_request(input t_cmd cmd, input t_side sd,
                                input logic [PRICE_PORT_W-1:0] px);
        int gap;
        gap = pick_gap(no_idle);
        @(negedge i_clk);
        req_cmd   <= cmd;
        req_side  <= sd;
        req_price <= px;
        start     <= 1'b1;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // watchdog: ends the run when nothing moves for too long
    initial begin
        idle_cycles = 0;
        @(posedge i_rst_n);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || result_valid)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [PRICE_PORT_W-1:0] base;
        t_resting                entry;
        bit                      filling;
        bit                      adding;
        bit                      reuse;
        int                      idx;

        no_idle = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty sides, extreme prices, crossed book
        send_request(CMD_REMOVE, SIDE_BID, 32'd7);
        send_request(CMD_REMOVE, SIDE_ASK, 32'hFFFF_FFFF);
        send_request(CMD_ADD,    SIDE_BID, 32'd0);
        send_request(CMD_ADD,    SIDE_ASK, 32'hFFFF_FFFF);
        send_request(CMD_ADD,    SIDE_BID, 32'hFFFF_FFFF);
        send_request(CMD_ADD,    SIDE_ASK, 32'd0);
        send_request(CMD_ADD,    SIDE_BID, 32'hFFFF_FFFF);
        send_request(CMD_REMOVE, SIDE_BID, 32'hFFFF_FFFF);
        send_request(CMD_REMOVE, SIDE_BID, 32'hFFFF_FFFF);
        send_request(CMD_REMOVE, SIDE_BID, 32'd5);
        send_request(CMD_REMOVE, SIDE_ASK, 32'd0);
        send_request(CMD_REMOVE, SIDE_ASK, 32'hFFFF_FFFF);
        send_request(CMD_REMOVE, SIDE_BID, 32'd0);
        // inserts and deletes at head, middle and tail
        send_request(CMD_ADD,    SIDE_BID, 32'd100);
        send_request(CMD_ADD,    SIDE_BID, 32'd300);
        send_request(CMD_ADD,    SIDE_BID, 32'd200);
        send_request(CMD_ADD,    SIDE_ASK, 32'd50);
        send_request(CMD_ADD,    SIDE_ASK, 32'd40);
        send_request(CMD_ADD,    SIDE_ASK, 32'd60);
        send_request(CMD_REMOVE, SIDE_BID, 32'd200);
        send_request(CMD_REMOVE, SIDE_BID, 32'd300);
        send_request(CMD_REMOVE, SIDE_ASK, 32'd60);
        send_request(CMD_REMOVE, SIDE_BID, 32'd100);
        send_request(CMD_REMOVE, SIDE_ASK, 32'd40);
        send_request(CMD_REMOVE, SIDE_ASK, 32'd50);

        // stack many orders on one level, then drain;
        // the level must vanish on exactly the last remove
        no_idle = 1'b1;
        send_request(CMD_ADD, SIDE_BID, BURST_PRICE + 1);
        for (int k = 0; k < BURST_ORDERS; k++)
            send_request(CMD_ADD, SIDE_ASK, BURST_PRICE);
        for (int k = 0; k < BURST_ORDERS; k++)
            send_request(CMD_REMOVE, SIDE_ASK, BURST_PRICE);
        send_request(CMD_REMOVE, SIDE_BID, BURST_PRICE + 1);

        // random: alternating fill and drain phases
        filling = 1'b1;
        base    = '0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 50 == 0)
                no_idle = ($urandom_range(0, 9) < 3);
            if (n % PHASE_LEN == 0) begin
                filling = ((n / PHASE_LEN) % 2) == 0;
                base    = $urandom;
            end
            adding = ($urandom_range(0, 99) < (filling ? 85 : 15));
            reuse  = (resting.size() != 0) && ($urandom_range(0, 99) < (adding ? 25 : 80));
            if (reuse) begin
                idx   = $urandom_range(0, resting.size() - 1);
                entry = resting[idx];
                if (!adding)
                    resting.delete(idx);
            end else begin
                entry.sd = t_side'($urandom_range(0, 1));
                entry.px = fresh_price(base);
            end
            if (adding)
                resting.push_back(entry);
            send_request(adding ? CMD_ADD : CMD_REMOVE, entry.sd, entry.px);
        end

        // drain the pipeline, then give the verdict
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
src/plb_pkg.sv
src/plb_cell.sv
src/plb_row.sv
src/price_level_book_top.sv
src/plb_checker.sv
tb/sv/plb_checker.sv
tb/sv/tb.sv
